FILE: design/ccsp_pkg.sv
package ccsp_pkg;
  localparam int LineMaxDefault    = 64;
  localparam int PayloadMaxDefault = 32;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [3:0] ChanMax  = 4'd7;

  typedef enum logic [1:0] {
    PH_PRE, PH_PAY, PH_HEX, PH_BAD
  } phase_t;

  typedef enum logic [2:0] {
    HX_WS, HX_SIGN, HX_ZERO, HX_X, HX_DIG, HX_DONE
  } hex_phase_t;

  typedef enum logic [1:0] {
    NM_WS, NM_DIG, NM_DONE
  } num_phase_t;

  // Per-line parse summary handed to the result stage at a line end.
  typedef struct packed {
    logic       framed;
    logic       good;
    logic [3:0] chan;
    logic [31:0] val;
    logic [7:0] calc;
    logic [7:0] recv;
  } line_sum_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
    if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic logic [7:0] name_char(input logic [2:0] p);
    unique case (p)
      3'd0: return 8'h53;
      3'd1: return 8'h43;
      3'd2: return 8'h43;
      3'd3: return 8'h4F;
      3'd4: return 8'h4E;
      default: return 8'h00;
    endcase
  endfunction
endpackage

FILE: design/ccsp_line.sv
module ccsp_line #(
  parameter int LineMax    = ccsp_pkg::LineMaxDefault,
  parameter int PayloadMax = ccsp_pkg::PayloadMaxDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          c,
  output logic                line_end,
  output ccsp_pkg::line_sum_t sum
);
  import ccsp_pkg::*;

  localparam int CW = $clog2(LineMax);
  localparam int PW = $clog2(PayloadMax + 1);

  logic [CW-1:0] line_count;
  phase_t        phase;
  logic          dead;
  hex_phase_t    hph;
  logic [PW-1:0] payload_len;
  logic [7:0]    xor_acc, hex_acc;
  logic [1:0]    tok_index;
  logic          in_tok, name_ok, neg_chan, neg_val;
  logic [2:0]    name_pos;
  num_phase_t    nph;
  logic [3:0]    chan_acc;
  logic [31:0]   val_acc;

  logic [CW-1:0] line_count_next;
  phase_t        phase_next;
  logic          dead_next;
  hex_phase_t    hph_next;
  logic [PW-1:0] payload_len_next;
  logic [7:0]    xor_acc_next, hex_acc_next;
  logic [1:0]    tok_index_next;
  logic          in_tok_next, name_ok_next, neg_chan_next, neg_val_next;
  logic [2:0]    name_pos_next;
  num_phase_t    nph_next;
  logic [3:0]    chan_acc_next;
  logic [31:0]   val_acc_next;
  logic [4:0]    hd;
  logic [7:0]    cm;
  logic [3:0]    d;
  logic [1:0]    ntok;

  always_comb begin
    line_count_next  = line_count + 1'b1;
    phase_next       = phase;
    dead_next        = dead;
    hph_next         = hph;
    payload_len_next = payload_len;
    xor_acc_next     = xor_acc;
    hex_acc_next     = hex_acc;
    tok_index_next   = tok_index;
    in_tok_next      = in_tok;
    name_ok_next     = name_ok;
    name_pos_next    = name_pos;
    nph_next         = nph;
    neg_chan_next    = neg_chan;
    neg_val_next     = neg_val;
    chan_acc_next    = chan_acc;
    val_acc_next     = val_acc;
    hd = hex_val(c);
    d  = c[3:0];
    cm = {4'd0, chan_acc} * 8'd10 + {4'd0, d};
    if (!dead) begin
      if (c == 8'd0) begin
        dead_next = 1'b1;
      end else begin
        unique case (phase)
          PH_PRE: begin
            if (c == ChDollar) phase_next = PH_PAY;
            else if (c == ChStar) phase_next = PH_BAD;
          end
          PH_PAY: begin
            if (c == ChStar) begin
              phase_next = PH_HEX;
            end else begin
              if (payload_len < PW'(PayloadMax)) payload_len_next = payload_len + 1'b1;
              xor_acc_next = xor_acc ^ c;
              if (c == ChComma) begin
                if (in_tok) begin
                  in_tok_next = 1'b0;
                  if (tok_index != 2'd3) tok_index_next = tok_index + 1'b1;
                end
              end else begin
                in_tok_next = 1'b1;
                if (tok_index == 2'd0) begin
                  logic [2:0] pos;
                  pos = in_tok ? name_pos : 3'd0;
                  if (!in_tok) name_ok_next = 1'b1;
                  if (pos < 3'd5 && c == name_char(pos)) name_pos_next = pos + 1'b1;
                  else begin
                    name_pos_next = pos;
                    name_ok_next  = 1'b0;
                  end
                end else if (tok_index != 2'd3) begin
                  num_phase_t ph;
                  ph = in_tok ? nph : NM_WS;
                  nph_next = ph;
                  if (ph != NM_DONE && !(ph == NM_WS && is_ws(c))) begin
                    if (ph == NM_WS && (c == ChPlus || c == ChMinus)) begin
                      if (tok_index == 2'd1) neg_chan_next = (c == ChMinus);
                      else neg_val_next = (c == ChMinus);
                      nph_next = NM_DIG;
                    end else if (!is_dec(c)) begin
                      nph_next = NM_DONE;
                    end else begin
                      nph_next = NM_DIG;
                      if (tok_index == 2'd1)
                        chan_acc_next = (chan_acc >= 4'd8 || cm > 8'd8) ? 4'd8 : cm[3:0];
                      else
                        val_acc_next = val_acc * 32'd10 + {28'd0, d};
                    end
                  end
                end
              end
            end
          end
          PH_HEX: begin
            if (hph == HX_DONE) begin
            end else if (hph == HX_WS && is_ws(c)) begin
            end else if (hph == HX_WS && (c == ChPlus || c == ChMinus)) begin
              hph_next = HX_SIGN;
            end else if ((hph == HX_WS || hph == HX_SIGN) && c == ChZero) begin
              hph_next = HX_ZERO;
            end else if (hph == HX_ZERO && (c == 8'h78 || c == 8'h58)) begin
              hph_next = HX_X;
            end else if (hd[4]) begin
              hex_acc_next = {hex_acc[3:0], hd[3:0]};
              hph_next = HX_DIG;
            end else begin
              hph_next = HX_DONE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign line_end = step && (c == ChCr || c == ChLf || line_count_next >= CW'(LineMax - 1));
  assign ntok     = tok_index_next + {1'b0, in_tok_next};

  always_comb begin
    sum.framed = phase_next == PH_HEX && payload_len_next < PW'(PayloadMax);
    sum.calc   = xor_acc_next;
    sum.recv   = hex_acc_next;
    sum.chan   = chan_acc_next;
    sum.val    = neg_val_next ? 32'd0 - val_acc_next : val_acc_next;
    sum.good   = sum.framed && xor_acc_next == hex_acc_next &&
                 (tok_index_next == 2'd3 || ntok == 2'd3) && name_ok_next &&
                 name_pos_next == 3'd5 && chan_acc_next <= ChanMax &&
                 (!neg_chan_next || chan_acc_next == 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst || line_end) begin
      line_count  <= '0;
      phase       <= PH_PRE;
      dead        <= 1'b0;
      hph         <= HX_WS;
      payload_len <= '0;
      xor_acc     <= '0;
      hex_acc     <= '0;
      tok_index   <= '0;
      in_tok      <= 1'b0;
      name_ok     <= 1'b0;
      name_pos    <= '0;
      nph         <= NM_WS;
      neg_chan    <= 1'b0;
      neg_val     <= 1'b0;
      chan_acc    <= '0;
      val_acc     <= '0;
    end else if (step) begin
      line_count  <= line_count_next;
      phase       <= phase_next;
      dead        <= dead_next;
      hph         <= hph_next;
      payload_len <= payload_len_next;
      xor_acc     <= xor_acc_next;
      hex_acc     <= hex_acc_next;
      tok_index   <= tok_index_next;
      in_tok      <= in_tok_next;
      name_ok     <= name_ok_next;
      name_pos    <= name_pos_next;
      nph         <= nph_next;
      neg_chan    <= neg_chan_next;
      neg_val     <= neg_val_next;
      chan_acc    <= chan_acc_next;
      val_acc     <= val_acc_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) $past(line_end) |-> line_count == '0)
    else $error("line count not cleared after line end");
  assert property (@(posedge clk) disable iff (rst) sum.good |-> sum.framed)
    else $error("good command without framing");
  assert property (@(posedge clk) disable iff (rst) payload_len <= PW'(PayloadMax))
    else $error("payload length overran");
endmodule

FILE: design/checked_command_sentence_parser.sv
// Channel | Signals                                   | Direction
// in      | in_valid, in_ready, rx_byte               | into block
// out     | out_valid, out_ready, cmd_valid, channel, | out of block
//         | value, checksum_calc, checksums_updated,  |
//         | checksum_recv                             |
// One item per cycle while no waiting result stalls the input; each byte updates the line state as it is taken.
// A line end (CR, LF or LineMax-1 bytes) loads the result register.
// A new byte is taken while the result register is empty or being drained.
// rst clears line state; held channel is -1, held value and checksums 0.
module checked_command_sentence_parser #(
  parameter int LineMax    = ccsp_pkg::LineMaxDefault,
  parameter int PayloadMax = ccsp_pkg::PayloadMaxDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               cmd_valid,
  output logic signed [3:0]  channel,
  output logic signed [31:0] value,
  output logic [7:0]         checksum_calc,
  output logic [7:0]         checksum_recv,
  output logic               checksums_updated
);
  import ccsp_pkg::*;

  logic      step, line_end;
  line_sum_t sum;
  logic [3:0]  held_channel;
  logic [31:0] held_value;
  logic [7:0]  held_calc, held_recv;

  // Take a byte unless a result waits and is not being taken.
  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  ccsp_line #(.LineMax(LineMax), .PayloadMax(PayloadMax)) u_line (
    .clk, .rst, .step, .c(rx_byte), .line_end, .sum
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      held_channel <= 4'hF;
      held_value   <= '0;
      held_calc    <= '0;
      held_recv    <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (line_end) begin
        out_valid         <= 1'b1;
        cmd_valid         <= sum.good;
        checksums_updated <= sum.framed;
        // Update the held fields now, and show their new values.
        if (sum.framed) begin
          held_calc <= sum.calc;
          held_recv <= sum.recv;
        end
        if (sum.good) begin
          held_channel <= sum.chan;
          held_value   <= sum.val;
        end
      end
    end
  end

  assign channel       = held_channel;
  assign value         = held_value;
  assign checksum_calc = held_calc;
  assign checksum_recv = held_recv;

  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst) line_end |-> step)
    else $error("line end without an item");
  assert property (@(posedge clk) disable iff (rst) out_valid && cmd_valid |-> checksums_updated)
    else $error("valid command not framed");
endmodule

FILE: sim/checked_command_sentence_parser_tb.sv
`timescale 1ns / 1ps

module checked_command_sentence_parser_tb;
  import ccsp_pkg::*;

  // Parser state mirrored by the model, with int counters where the block uses narrow fields.
  typedef struct {
    int unsigned  nbytes;
    phase_t       phase;
    bit           dead;
    hex_phase_t   hex_phase;
    int unsigned  pay_len;
    logic [7:0]   xsum;
    logic [7:0]   hsum;
    int unsigned  tok_idx;
    bit           in_tok;
    int unsigned  name_pos;
    bit           name_ok;
    num_phase_t   num_phase;
    bit           neg_chan;
    bit           neg_val;
    logic [4:0]   chan_mag;
    logic [31:0]  val_mag;
  } line_state_t;

  typedef struct {
    logic        good;
    logic [3:0]  chan;
    logic [31:0] val;
    logic [7:0]  calc;
    logic [7:0]  recv;
    logic        framed;
  } line_result_t;

  class line_scoreboard;
    line_state_t  ls;
    logic [3:0]   last_chan;
    logic [31:0]  last_val;
    logic [7:0]   last_calc;
    logic [7:0]   last_recv;
    line_result_t pending[$];
    int           errors;

    function new();
      clear_line();
      last_chan = 4'hF;
      last_val = '0;
      last_calc = '0;
      last_recv = '0;
      errors = 0;
    endfunction

    function void clear_line();
      ls = '{0, PH_PRE, 0, HX_WS, 0, 8'h0, 8'h0, 0, 0, 0, 0, NM_WS, 0, 0, 5'd0, 32'd0};
    endfunction

    function bit ws(logic [7:0] c);
      return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function int hexd(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
    endfunction

    function void feed_hex(logic [7:0] c);
      int d;
      d = hexd(c);
      if (ls.hex_phase == HX_DONE) return;
      if (ls.hex_phase == HX_WS && ws(c)) return;
      if (ls.hex_phase == HX_WS && (c == ChPlus || c == ChMinus)) begin
        ls.hex_phase = HX_SIGN;
        return;
      end
      if ((ls.hex_phase == HX_WS || ls.hex_phase == HX_SIGN) && c == ChZero) begin
        ls.hex_phase = HX_ZERO;
        return;
      end
      if (ls.hex_phase == HX_ZERO && (c == "x" || c == "X")) begin
        ls.hex_phase = HX_X;
        return;
      end
      if (d >= 0) begin
        ls.hsum = {ls.hsum[3:0], 4'(d)};
        ls.hex_phase = HX_DIG;
      end else begin
        ls.hex_phase = HX_DONE;
      end
    endfunction

    function void feed_num(logic [7:0] c, bit is_chan);
      bit dig;
      logic [3:0] d;
      dig = c >= "0" && c <= "9";
      d = 4'(c - "0");
      if (ls.num_phase == NM_DONE) return;
      if (ls.num_phase == NM_WS) begin
        if (ws(c)) return;
        if (c == ChPlus || c == ChMinus) begin
          if (is_chan) ls.neg_chan = (c == ChMinus);
          else ls.neg_val = (c == ChMinus);
          ls.num_phase = NM_DIG;
          return;
        end
      end
      if (!dig) begin
        ls.num_phase = NM_DONE;
        return;
      end
      ls.num_phase = NM_DIG;
      if (is_chan) begin
        int m;
        m = (ls.chan_mag >= 8) ? 8 : ls.chan_mag * 10 + d;
        ls.chan_mag = (m > 8) ? 5'd8 : 5'(m);
      end else begin
        ls.val_mag = ls.val_mag * 32'd10 + 32'(d);
      end
    endfunction

    function void feed_token(logic [7:0] c);
      if (c == ChComma) begin
        if (ls.in_tok) begin
          ls.in_tok = 0;
          if (ls.tok_idx < 3) ls.tok_idx++;
        end
        return;
      end
      if (!ls.in_tok) begin
        ls.in_tok = 1;
        if (ls.tok_idx == 0) begin
          ls.name_pos = 0;
          ls.name_ok = 1;
        end else begin
          ls.num_phase = NM_WS;
        end
      end
      if (ls.tok_idx == 0) begin
        if (ls.name_pos < 5 && c == name_char(3'(ls.name_pos))) ls.name_pos++;
        else ls.name_ok = 0;
      end else if (ls.tok_idx == 1) begin
        feed_num(c, 1);
      end else if (ls.tok_idx == 2) begin
        feed_num(c, 0);
      end
    endfunction

    // Note one accepted byte; queue a result at a line end.
    function void note_byte(logic [7:0] c);
      line_result_t r;
      int unsigned ntok;
      ls.nbytes++;
      if (!ls.dead) begin
        if (c == 8'h00) ls.dead = 1;
        else if (ls.phase == PH_PRE) begin
          if (c == ChDollar) ls.phase = PH_PAY;
          else if (c == ChStar) ls.phase = PH_BAD;
        end else if (ls.phase == PH_PAY) begin
          if (c == ChStar) ls.phase = PH_HEX;
          else begin
            if (ls.pay_len < PayloadMaxDefault) ls.pay_len++;
            ls.xsum ^= c;
            feed_token(c);
          end
        end else if (ls.phase == PH_HEX) begin
          feed_hex(c);
        end
      end
      if (!(c == ChCr || c == ChLf || ls.nbytes >= LineMaxDefault - 1)) return;
      r.framed = ls.phase == PH_HEX && ls.pay_len < PayloadMaxDefault;
      r.good = 0;
      if (r.framed) begin
        last_calc = ls.xsum;
        last_recv = ls.hsum;
        ntok = ls.tok_idx + (ls.in_tok ? 1 : 0);
        if (ls.xsum == ls.hsum && ntok >= 3 && ls.name_ok && ls.name_pos == 5 &&
            ls.chan_mag <= 7 && (!ls.neg_chan || ls.chan_mag == 0)) begin
          r.good = 1;
          last_chan = ls.chan_mag[3:0];
          last_val = ls.neg_val ? -ls.val_mag : ls.val_mag;
        end
      end
      r.chan = last_chan;
      r.val = last_val;
      r.calc = last_calc;
      r.recv = last_recv;
      pending.push_back(r);
      clear_line();
    endfunction

    function void check_result(line_result_t got);
      line_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result cmd_valid=%0b", $realtime, got.good);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.good !== exp_r.good) begin
        $display("%0t: cmd_valid exp %0b got %0b", $realtime, exp_r.good, got.good);
        errors++;
      end
      if (got.chan !== exp_r.chan) begin
        $display("%0t: channel exp %0h got %0h", $realtime, exp_r.chan, got.chan);
        errors++;
      end
      if (got.val !== exp_r.val) begin
        $display("%0t: value exp %0h got %0h", $realtime, exp_r.val, got.val);
        errors++;
      end
      if (got.calc !== exp_r.calc) begin
        $display("%0t: checksum_calc exp %0h got %0h", $realtime, exp_r.calc, got.calc);
        errors++;
      end
      if (got.recv !== exp_r.recv) begin
        $display("%0t: checksum_recv exp %0h got %0h", $realtime, exp_r.recv, got.recv);
        errors++;
      end
      if (got.framed !== exp_r.framed) begin
        $display("%0t: checksums_updated exp %0b got %0b", $realtime, exp_r.framed,
                 got.framed);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  logic [7:0]         rx_byte = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic               cmd_valid;
  logic signed [3:0]  channel;
  logic signed [31:0] value;
  logic [7:0]         checksum_calc;
  logic [7:0]         checksum_recv;
  logic               checksums_updated;

  line_scoreboard sb = new();
  int  bytes_sent = 0;
  bit  calm = 0;            // set in the last part of the run: no idling
  longint cycles = 0;

  localparam longint CycleLimit = 2_000_000;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  checked_command_sentence_parser dut (
    .clk, .rst, .in_valid, .in_ready, .rx_byte, .out_valid, .out_ready,
    .cmd_valid, .channel, .value, .checksum_calc, .checksum_recv, .checksums_updated
  );

  // Sample both handshakes on the edge; the model sees bytes in order.
  always @(posedge clk) begin
    cycles++;
    if (!rst && in_valid && in_ready) sb.note_byte(rx_byte);
    if (!rst && out_valid && out_ready)
      sb.check_result('{cmd_valid, channel, value, checksum_calc, checksum_recv,
                        checksums_updated});
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: take results, stalling in random bursts until the calm phase.
  initial begin
    int gap;
    @(posedge clk iff !rst);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 18);
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
    end
  end

  // Drive one byte and hold it until accepted; maybe idle first.
  task automatic send_byte(logic [7:0] b);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  function automatic string hex2(logic [7:0] v);
    return $sformatf("%02X", v);
  endfunction

  function automatic logic [7:0] xor_of(string s);
    logic [7:0] x;
    x = 0;
    foreach (s[i]) x ^= s[i];
    return x;
  endfunction

  // Send a checksummed sentence with the given payload and line ending.
  task automatic send_sentence(string pay, bit good_sum, string tail);
    logic [7:0] x;
    x = xor_of(pay);
    if (!good_sum) x ^= 8'(1 << $urandom_range(0, 7));
    send_text({"$", pay, "*", hex2(x), tail});
  endtask

  function automatic string rand_num();
    case ($urandom_range(0, 5))
      0: return $sformatf("%0d", $urandom_range(0, 9));
      1: return $sformatf("-%0d", $urandom);
      2: return $sformatf("%0d%0d", $urandom, $urandom);
      3: return $sformatf(" +%0d", $urandom_range(0, 99));
      4: return "";
      default: return $sformatf("%0d", $signed($urandom));
    endcase
  endfunction

  function automatic string rand_payload();
    string s, ch;
    int n;
    case ($urandom_range(0, 9))
      0: ch = $sformatf("%0d", $urandom_range(8, 40));
      1: ch = "-0";
      2: ch = "-3";
      default: ch = $sformatf("%0d", $urandom_range(0, 7));
    endcase
    s = ($urandom_range(0, 9) == 0) ? "SCCOM" : "SCCON";
    s = {s, ($urandom_range(0, 4) == 0) ? ",," : ",", ch, ",", rand_num()};
    if ($urandom_range(0, 5) == 0) s = {s, ",x9"};
    if ($urandom_range(0, 6) == 0) s = {",", s};
    n = 0;
    while (s.len() > 34 && n < 1) n++;
    return s;
  endfunction

  task automatic send_noise(int n);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: send_byte(ChLf);
        1: send_byte(ChCr);
        2: send_byte(ChDollar);
        3: send_byte(ChStar);
        4: send_byte(8'h00);
        default: send_byte(8'($urandom));
      endcase
    end
  endtask

  // Hold off the sender until the last accepted byte is noted, then wait until every queued result is checked.
  task automatic wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    string p;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: good commands, channel/value extremes, checksum forms, framing faults.
    send_sentence("SCCON,7,2147483647", 1, "\n");
    send_sentence("SCCON,0,-2147483648", 1, "\r");
    send_sentence("SCCON,-0,4294967297", 1, "\n");
    send_sentence("SCCON,9,1", 1, "\n");
    send_sentence("SCCON,-1,1", 1, "\n");
    send_sentence("SCCON,,,3,,5", 1, "\n");
    send_sentence("SCCON,3,5", 0, "\n");
    send_sentence("SCCOX,3,5", 1, "\n");
    send_sentence("SCCON,3", 1, "\n");
    p = "SCCON,2,12";
    send_text({"junk$", p, "* -0x", hex2(xor_of(p)), "zz\n"});
    send_text({"$", p, "*+0X1", hex2(xor_of(p)), "\r"});
    send_text({"$", p, "*\n"});
    send_text("no dollar here\n");
    send_text("*SCCON$,1,1*00\n");
    send_text("$SCCON,1,1,extra,garbage,0123456789*00\n");
    send_text({"$SCCON,4,4*", hex2(xor_of("SCCON,4,4")), 8'h00, "\n"});
    send_text({"$SCCO", 8'h00, "N,4,4*00\n"});
    repeat (63) send_byte(8'hFF);
    send_text({" \t$", p, "*\t", hex2(xor_of(p)), "\n"});
    wait_drained();

    // Random: mostly well-formed sentences, some noise, until ~1650 bytes.
    while (bytes_sent < 1650) begin
      if (bytes_sent > 1300) calm = 1;
      if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 12));
      else send_sentence(rand_payload(), $urandom_range(0, 4) != 0,
                         $urandom_range(0, 1) ? "\n" : "\r");
      if (bytes_sent > 700 && bytes_sent < 760) wait_drained();
    end
    send_byte(ChLf);
    wait_drained();

    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
